FILE: hw/rtl/ttrm_pkg.sv
`timescale 1ns / 1ps

package ttrm_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int IN_COORD_W     = 12;
  localparam int QUEUE_DEPTH    = 2;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam int THRESH_W   = 8;
  localparam int GAIN_W     = 4;
  localparam int BTN_W      = 3;
  localparam int MOVE_W     = 8;

  localparam logic [CFG_IDX_W-1:0] REG_CLICK_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOTION_GAIN     = 1'd1;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd3;
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 4'd3;

  localparam logic [BTN_W-1:0] BTN_NONE = 3'b000;
  localparam logic [BTN_W-1:0] BTN_LEFT = 3'b001;

  typedef enum logic [0:0] {
    CMD_MOVE = 1'b0,
    CMD_TAP  = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [MOVE_W-1:0] move_x;
    logic [MOVE_W-1:0] move_y;
  } cmd_t;

  typedef struct packed {
    logic [BTN_W-1:0]  buttons;
    logic [MOVE_W-1:0] move_x;
    logic [MOVE_W-1:0] move_y;
    logic              last_of_run;
  } report_t;

  typedef enum logic [0:0] {
    BK_RUN     = 1'b0,
    BK_RELEASE = 1'b1
  } back_state_t;

endpackage

FILE: hw/rtl/ttrm_fifo.sv
`timescale 1ns / 1ps

module ttrm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = ttrm_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] dout
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

FILE: hw/rtl/ttrm_front.sv
`timescale 1ns / 1ps

module ttrm_front #(
  parameter int COORD_BITS = ttrm_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [ttrm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ttrm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic                                in_touch_present,
  input  logic [ttrm_pkg::IN_COORD_W-1:0]     in_touch_x,
  input  logic [ttrm_pkg::IN_COORD_W-1:0]     in_touch_y,
  output logic                                cmd_push,
  input  logic                                cmd_full,
  output ttrm_pkg::cmd_t                      cmd
);

  localparam int W  = COORD_BITS;
  localparam int MW = ttrm_pkg::MOVE_W;
  localparam int PW = ttrm_pkg::MOVE_W + ttrm_pkg::GAIN_W;

  logic [ttrm_pkg::THRESH_W-1:0] thresh_r, thresh_nxt;
  logic [ttrm_pkg::GAIN_W-1:0]   gain_r, gain_nxt;
  logic [W-1:0] prev_x_r, prev_x_nxt;
  logic [W-1:0] prev_y_r, prev_y_nxt;
  logic [W-1:0] start_x_r, start_x_nxt;
  logic [W-1:0] start_y_r, start_y_nxt;
  logic         in_touch_r, in_touch_nxt;
  logic         tap_pending_r, tap_pending_nxt;

  logic [W+ttrm_pkg::IN_COORD_W-1:0] x_ext, y_ext;
  logic [W-1:0]  x, y;
  logic [MW-1:0] dx, dy;
  logic [PW-1:0] prod_x, prod_y;
  logic [W-1:0]  dist_x, dist_y;
  logic          moved_away;
  logic          accept;

  assign x_ext = {{W{1'b0}}, in_touch_x};
  assign y_ext = {{W{1'b0}}, in_touch_y};
  assign x     = x_ext[W-1:0];
  assign y     = y_ext[W-1:0];

  assign dx     = x[MW-1:0] - prev_x_r[MW-1:0];
  assign dy     = y[MW-1:0] - prev_y_r[MW-1:0];
  assign prod_x = {{ttrm_pkg::GAIN_W{1'b0}}, dx} * {{MW{1'b0}}, gain_r};
  assign prod_y = {{ttrm_pkg::GAIN_W{1'b0}}, dy} * {{MW{1'b0}}, gain_r};

  assign dist_x     = (x >= start_x_r) ? (x - start_x_r) : (start_x_r - x);
  assign dist_y     = (y >= start_y_r) ? (y - start_y_r) : (start_y_r - y);
  assign moved_away = (dist_x > W'(thresh_r)) || (dist_y > W'(thresh_r));

  assign in_full = cmd_full;
  assign accept  = in_push && !cmd_full;

  always_comb begin
    cmd_push    = 1'b0;
    cmd.kind    = ttrm_pkg::CMD_MOVE;
    cmd.move_x  = prod_x[MW-1:0];
    cmd.move_y  = prod_y[MW-1:0];
    if (accept) begin
      if (in_touch_present) begin
        cmd_push = in_touch_r;
      end else begin
        cmd_push = tap_pending_r;
        cmd.kind = ttrm_pkg::CMD_TAP;
      end
    end
  end

  always_comb begin
    thresh_nxt      = thresh_r;
    gain_nxt        = gain_r;
    prev_x_nxt      = prev_x_r;
    prev_y_nxt      = prev_y_r;
    start_x_nxt     = start_x_r;
    start_y_nxt     = start_y_r;
    in_touch_nxt    = in_touch_r;
    tap_pending_nxt = tap_pending_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        ttrm_pkg::REG_CLICK_THRESHOLD: thresh_nxt = cfg_data[ttrm_pkg::THRESH_W-1:0];
        ttrm_pkg::REG_MOTION_GAIN:     gain_nxt   = cfg_data[ttrm_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
    if (accept) begin
      if (in_touch_present) begin
        prev_x_nxt = x;
        prev_y_nxt = y;
        if (!in_touch_r) begin
          in_touch_nxt    = 1'b1;
          tap_pending_nxt = 1'b1;
          start_x_nxt     = x;
          start_y_nxt     = y;
        end else if (moved_away) begin
          tap_pending_nxt = 1'b0;
        end
      end else begin
        in_touch_nxt    = 1'b0;
        tap_pending_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r      <= ttrm_pkg::THRESH_RESET;
      gain_r        <= ttrm_pkg::GAIN_RESET;
      prev_x_r      <= '0;
      prev_y_r      <= '0;
      start_x_r     <= '0;
      start_y_r     <= '0;
      in_touch_r    <= 1'b0;
      tap_pending_r <= 1'b0;
    end else begin
      thresh_r      <= thresh_nxt;
      gain_r        <= gain_nxt;
      prev_x_r      <= prev_x_nxt;
      prev_y_r      <= prev_y_nxt;
      start_x_r     <= start_x_nxt;
      start_y_r     <= start_y_nxt;
      in_touch_r    <= in_touch_nxt;
      tap_pending_r <= tap_pending_nxt;
    end
  end

endmodule

FILE: hw/rtl/ttrm_back.sv
`timescale 1ns / 1ps

module ttrm_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_empty,
  input  ttrm_pkg::cmd_t    cmd,
  output logic              cmd_pop,
  input  logic              rpt_full,
  output logic              rpt_push,
  output ttrm_pkg::report_t rpt
);

  ttrm_pkg::back_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ttrm_pkg::BK_RUN: begin
        if (!cmd_empty && !rpt_full && cmd.kind == ttrm_pkg::CMD_TAP) begin
          state_nxt = ttrm_pkg::BK_RELEASE;
        end
      end
      ttrm_pkg::BK_RELEASE: begin
        if (!rpt_full) begin
          state_nxt = ttrm_pkg::BK_RUN;
        end
      end
      default: state_nxt = ttrm_pkg::BK_RUN;
    endcase
  end

  always_comb begin
    cmd_pop         = 1'b0;
    rpt_push        = 1'b0;
    rpt.buttons     = ttrm_pkg::BTN_NONE;
    rpt.move_x      = '0;
    rpt.move_y      = '0;
    rpt.last_of_run = 1'b1;
    case (state_r)
      ttrm_pkg::BK_RUN: begin
        rpt_push = !cmd_empty && !rpt_full;
        if (cmd.kind == ttrm_pkg::CMD_TAP) begin
          // press beat first, hold the command for the release beat
          rpt.buttons     = ttrm_pkg::BTN_LEFT;
          rpt.last_of_run = 1'b0;
        end else begin
          rpt.move_x = cmd.move_x;
          rpt.move_y = cmd.move_y;
          cmd_pop    = !cmd_empty && !rpt_full;
        end
      end
      ttrm_pkg::BK_RELEASE: begin
        rpt_push = !rpt_full;
        cmd_pop  = !rpt_full;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ttrm_pkg::BK_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hw/rtl/touch_to_relative_mouse.sv
`timescale 1ns / 1ps
// Path: a report made from a sample goes through the command queue and then the report
// queue to the out_ ports; the release report of a tap is pushed from BK_RELEASE.
// Throughput: one sample per cycle when in_full is low; a tap release holds ttrm_back.
// Reset: synchronous active-low rst_n clears touch state and empties both queues;
// click_threshold and motion_gain return to 3.
module touch_to_relative_mouse #(
  parameter int COORD_BITS  = ttrm_pkg::COORD_BITS_DEF,
  parameter int QUEUE_DEPTH = ttrm_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [ttrm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ttrm_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic                              in_touch_present,
  input  logic [ttrm_pkg::IN_COORD_W-1:0]   in_touch_x,
  input  logic [ttrm_pkg::IN_COORD_W-1:0]   in_touch_y,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [ttrm_pkg::BTN_W-1:0]        out_buttons,
  output logic signed [ttrm_pkg::MOVE_W-1:0] out_move_x,
  output logic signed [ttrm_pkg::MOVE_W-1:0] out_move_y,
  output logic                              out_last_of_run
);

  localparam int CMD_W = $bits(ttrm_pkg::cmd_t);
  localparam int RPT_W = $bits(ttrm_pkg::report_t);

  logic              cmd_push, cmd_full, cmd_empty, cmd_pop;
  ttrm_pkg::cmd_t    cmd_in, cmd_out;
  logic              rpt_push, rpt_full;
  ttrm_pkg::report_t rpt_in, rpt_out;

  ttrm_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_touch_present (in_touch_present),
    .in_touch_x       (in_touch_x),
    .in_touch_y       (in_touch_y),
    .cmd_push         (cmd_push),
    .cmd_full         (cmd_full),
    .cmd              (cmd_in)
  );

  ttrm_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .full  (cmd_full),
    .din   (cmd_in),
    .pop   (cmd_pop),
    .empty (cmd_empty),
    .dout  (cmd_out)
  );

  ttrm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .rpt_full  (rpt_full),
    .rpt_push  (rpt_push),
    .rpt       (rpt_in)
  );

  ttrm_fifo #(
    .WIDTH(RPT_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_rpt_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rpt_push),
    .full  (rpt_full),
    .din   (rpt_in),
    .pop   (out_pop),
    .empty (out_empty),
    .dout  (rpt_out)
  );

  assign out_buttons     = rpt_out.buttons;
  assign out_move_x      = rpt_out.move_x;
  assign out_move_y      = rpt_out.move_y;
  assign out_last_of_run = rpt_out.last_of_run;

endmodule
